[src/bbe_pkg.sv]
// Shared types, constants and the reciprocal table of the band equaliser.
`default_nettype none
package bbe_pkg;

  localparam int unsigned MAX_BANDS = 32;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned COEF_W    = 20;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned RECIP_W   = 22;
  localparam int unsigned RECIP_SH  = 21;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_MB, ST_MA1, ST_MA2, ST_ACC, ST_SAT, ST_DIV, ST_SUM, ST_OUT
  } state_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  typedef struct packed {
    logic             start;    // sample request taken
    logic             wr;       // coefficient request taken
    logic             rd;       // read band coefs and history
    logic             mul_b;
    logic             mul_a1;
    logic             mul_a2;
    logic             acc_end;
    logic             sat;
    logic             div;
    logic             sum;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic band_en;
    logic count_zero;
  } sts_t;

  // ceil(2^21 / c): exact quotient for |y| <= 32768 and c <= 32
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
    logic [RECIP_W-1:0] r;
    unique case (c)
      6'd1:  r = 22'd2097152;
      6'd2:  r = 22'd1048576;
      6'd3:  r = 22'd699051;
      6'd4:  r = 22'd524288;
      6'd5:  r = 22'd419431;
      6'd6:  r = 22'd349526;
      6'd7:  r = 22'd299594;
      6'd8:  r = 22'd262144;
      6'd9:  r = 22'd233017;
      6'd10: r = 22'd209716;
      6'd11: r = 22'd190651;
      6'd12: r = 22'd174763;
      6'd13: r = 22'd161320;
      6'd14: r = 22'd149797;
      6'd15: r = 22'd139811;
      6'd16: r = 22'd131072;
      6'd17: r = 22'd123362;
      6'd18: r = 22'd116509;
      6'd19: r = 22'd110377;
      6'd20: r = 22'd104858;
      6'd21: r = 22'd99865;
      6'd22: r = 22'd95326;
      6'd23: r = 22'd91181;
      6'd24: r = 22'd87382;
      6'd25: r = 22'd83887;
      6'd26: r = 22'd80660;
      6'd27: r = 22'd77673;
      6'd28: r = 22'd74899;
      6'd29: r = 22'd72316;
      6'd30: r = 22'd69906;
      6'd31: r = 22'd67651;
      6'd32: r = 22'd65536;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/bbe_datapath.sv]
// Datapath: band stores, shared multiplier, saturation, divide-by-count and sum.
`default_nettype none
module bbe_datapath import bbe_pkg::*; #(
  parameter int unsigned BAND_COUNT     = 31,
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  input  wire logic [IDX_W-1:0]         band_i,
  input  wire logic signed [COEF_W-1:0] coef_b_i,
  input  wire logic signed [COEF_W-1:0] coef_a1_i,
  input  wire logic signed [COEF_W-1:0] coef_a2_i,
  input  wire logic                     band_on_i,
  input  wire logic signed [SMP_W-1:0]  sample_i,
  input  wire logic                     period_start_i,
  output logic [SMP_W-1:0]              sample_o
);

  logic [3*COEF_W-1:0] coef_mem [MAX_BANDS];
  logic [4*SMP_W-1:0]  hist_mem [MAX_BANDS];
  logic [MAX_BANDS-1:0] en_q, hv_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [3*COEF_W-1:0] coef_q;
  logic [4*SMP_W-1:0]  hist_rd_q;
  logic                hv_rd_q;
  logic signed [SMP_W-1:0] x_q, y_q;
  logic signed [ACC_W-1:0] prod_q, acc_q;
  logic [SMP_W+RECIP_W:0]  dprod_q;
  logic [SMP_W-1:0]    sum_q, out_q;

  logic [4*SMP_W-1:0]  hist;
  logic signed [SMP_W-1:0] hx1, hx2, hy1, hy2, y_sat;
  logic signed [COEF_W-1:0] cb, ca1, ca2;
  logic signed [SMP_W:0]    xdiff;
  logic wr_ok;

  assign hist = hv_rd_q ? hist_rd_q : '0;
  assign hx1 = hist[SMP_W-1:0];
  assign hx2 = hist[2*SMP_W-1:SMP_W];
  assign hy1 = hist[3*SMP_W-1:2*SMP_W];
  assign hy2 = hist[4*SMP_W-1:3*SMP_W];
  assign cb  = coef_q[COEF_W-1:0];
  assign ca1 = coef_q[2*COEF_W-1:COEF_W];
  assign ca2 = coef_q[3*COEF_W-1:2*COEF_W];
  assign xdiff = {x_q[SMP_W-1], x_q} - {hx2[SMP_W-1], hx2};
  assign wr_ok = cmd_i.wr && (32'(band_i) < BAND_COUNT);

  // truncate toward zero, saturate to 16 bits
  always_comb begin
    logic [ACC_W-1:0] mag, q;
    mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    q   = mag >> COEF_FRAC_BITS;
    if (acc_q[ACC_W-1]) begin
      y_sat = (q > ACC_W'(32768)) ? SMP_W'(16'h8000) : SMP_W'(-q);
    end else begin
      y_sat = (q > ACC_W'(32767)) ? SMP_W'(16'h7fff) : q[SMP_W-1:0];
    end
  end

  assign sts_o.band_en    = en_q[cmd_i.idx];
  assign sts_o.count_zero = (cnt_q == '0);
  assign sample_o = out_q;

  // band stores, no reset needed: read only once enabled, hence written
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      coef_mem[band_i] <= {coef_a2_i, coef_a1_i, coef_b_i};
    end
    if (cmd_i.sat) begin
      hist_mem[cmd_i.idx] <= {hy1, y_sat, hx1, x_q};
    end
    if (cmd_i.rd) begin
      coef_q    <= coef_mem[cmd_i.idx];
      hist_rd_q <= hist_mem[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= '0;
      hv_q    <= '0;
      cnt_q   <= '0;
      hv_rd_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        en_q[band_i] <= band_on_i;
        if (band_on_i && !en_q[band_i]) cnt_q <= cnt_q + 1'b1;
        if (!band_on_i && en_q[band_i]) cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.start && period_start_i) begin
        hv_q <= '0;
      end else if (cmd_i.sat) begin
        hv_q[cmd_i.idx] <= 1'b1;
      end
      if (cmd_i.rd) hv_rd_q <= hv_q[cmd_i.idx] && !(cmd_i.start && period_start_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q   <= sample_i;
      sum_q <= (cnt_q == '0) ? sample_i : '0;
    end
    if (cmd_i.mul_b)  prod_q <= ACC_W'(cb * xdiff);
    if (cmd_i.mul_a1) begin
      acc_q  <= prod_q;
      prod_q <= ACC_W'(ca1 * hy1);
    end
    if (cmd_i.mul_a2) begin
      acc_q  <= acc_q - prod_q;
      prod_q <= ACC_W'(ca2 * hy2);
    end
    if (cmd_i.acc_end) acc_q <= acc_q - prod_q;
    if (cmd_i.sat)     y_q   <= y_sat;
    if (cmd_i.div) begin
      dprod_q <= (SMP_W+RECIP_W+1)'((y_q[SMP_W-1] ? 17'(-{y_q[SMP_W-1], y_q})
                                                : 17'({1'b0, y_q})) * recip(cnt_q));
    end
    if (cmd_i.sum) begin
      sum_q <= sum_q + (y_q[SMP_W-1] ? SMP_W'(-(dprod_q >> RECIP_SH))
                                     : SMP_W'(dprod_q >> RECIP_SH));
    end
    if (cmd_i.out_load) out_q <= sum_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == $countones(en_q[MAX_BANDS-1:0]))
    else $error("enabled count out of step with enable bits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sat |-> en_q[cmd_i.idx])
    else $error("history written for a disabled band");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && period_start_i) |=> (hv_q == '0))
    else $error("histories not cleared at period start");

endmodule
`default_nettype wire

[src/bbe_ctrl.sv]
// Controller: request handshakes and the per-band sequencing state machine.
`default_nettype none
module bbe_ctrl import bbe_pkg::*; #(
  parameter int unsigned BAND_COUNT = 31
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_valid_i,
  output logic      s_ready_o,
  input  wire logic op_i,
  output logic      m_valid_o,
  input  wire logic m_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic m_valid_q, m_valid_d;
  logic take, idx_end;

  assign s_ready_o = (state_q == ST_IDLE);
  assign take      = s_valid_i && s_ready_o;
  assign idx_end   = (32'(idx_q) >= BAND_COUNT);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q[IDX_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (take && op_e'(op_i) == OP_WRITE) begin
          cmd_o.wr = 1'b1;
        end else if (take) begin
          cmd_o.start = 1'b1;
          idx_d   = '0;
          state_d = sts_i.count_zero ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_end) begin
          state_d = ST_OUT;
        end else if (sts_i.band_en) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_MB;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MB:  begin cmd_o.mul_b   = 1'b1; state_d = ST_MA1; end
      ST_MA1: begin cmd_o.mul_a1  = 1'b1; state_d = ST_MA2; end
      ST_MA2: begin cmd_o.mul_a2  = 1'b1; state_d = ST_ACC; end
      ST_ACC: begin cmd_o.acc_end = 1'b1; state_d = ST_SAT; end
      ST_SAT: begin cmd_o.sat     = 1'b1; state_d = ST_DIV; end
      ST_DIV: begin cmd_o.div     = 1'b1; state_d = ST_SUM; end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = ST_SCAN;
      end
      ST_OUT: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    m_valid_d = cmd_o.out_load ? 1'b1 : (m_ready_i ? 1'b0 : m_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!m_valid_q || m_ready_i))
    else $error("result overwritten before taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.start && !sts_i.count_zero) |=> (state_q == ST_SCAN && idx_q == '0))
    else $error("band scan not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> (state_q == ST_MB && $stable(idx_q)))
    else $error("band index moved during band work");

endmodule
`default_nettype wire

[src/biquad_band_equalizer.sv]
// Top level of the biquad band-pass graphic equaliser.
// Sample request: the controller scans the bands in order and runs each enabled band through
//   the multiply, accumulate, saturate, divide and sum states, or passes with none enabled.
// Requests: one at a time; after a sample the input waits until its result is loaded, which
//   waits while the previous result is not taken; a write is done from idle.
// Reset: asynchronous, active low; clears enables, count and history valid bits at once.
`default_nettype none
module biquad_band_equalizer import bbe_pkg::*; #(
  parameter int unsigned BAND_COUNT     = 31,
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // band[4:0], coef_b[24:5], coef_a1[44:25], coef_a2[64:45], band_on[65],
  // sample_in[81:66], period_start[82], zero pad[87:83]
  input  wire logic [87:0] s_axis_tdata,
  // op[0]: 0 sample, 1 coefficient write
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // sample_out[15:0]
  output logic [15:0]      m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  // controller sequences one band at a time
  bbe_ctrl #(.BAND_COUNT(BAND_COUNT)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .op_i      (s_axis_tuser[0]),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath holds band stores and the arithmetic
  bbe_datapath #(
    .BAND_COUNT    (BAND_COUNT),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .band_i         (s_axis_tdata[4:0]),
    .coef_b_i       (s_axis_tdata[24:5]),
    .coef_a1_i      (s_axis_tdata[44:25]),
    .coef_a2_i      (s_axis_tdata[64:45]),
    .band_on_i      (s_axis_tdata[65]),
    .sample_i       (s_axis_tdata[81:66]),
    .period_start_i (s_axis_tdata[82]),
    .sample_o       (m_axis_tdata)
  );

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking stream testbench for the biquad band equaliser.
module tb;
  import bbe_pkg::*;

  localparam int NBANDS     = 31;
  localparam int FRAC       = 16;
  localparam int IDLE_LIMIT = 4000;  // cycles with no request moved on either side
  localparam int HOLD_LEN   = 900;   // long receiver hold-off

  typedef struct {
    op_e                op;
    logic [4:0]         band;
    logic signed [19:0] cb, ca1, ca2;
    logic               on;
    logic signed [15:0] smp;
    logic               ps;
    bit                 sync;  // wait until every expected sample is out
  } eq_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic m_ready = 1'b0;
  eq_req_t cur = '{OP_SAMPLE, 5'd0, 20'sd0, 20'sd0, 20'sd0, 1'b0, 16'sd0, 1'b0, 1'b0};
  logic s_axis_tready, m_axis_tvalid;
  logic [15:0] m_axis_tdata;

  eq_req_t pend[$];
  logic [15:0] exp_samples[$];

  // predictor state
  logic signed [19:0] mb[32], ma1[32], ma2[32];
  bit mon[32];
  int hx1[32], hx2[32], hy1[32], hy2[32];
  int mcount;

  int errors = 0, n_samples = 0, n_writes = 0, n_out = 0, idle = 0;
  bit in_taken = 1'b0;

  biquad_band_equalizer DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata({5'b0, cur.ps, cur.smp, cur.on, cur.ca2, cur.ca1, cur.cb, cur.band}),
    .s_axis_tuser(cur.op),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial forever #2 clk_i = ~clk_i;

  function automatic int trunc_sat16(longint acc);
    longint q;
    q = (acc < 0) ? -((-acc) >>> FRAC) : (acc >>> FRAC);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  // Runs one request through the predictor; a sample queues its output.
  task automatic equalise(input eq_req_t r);
    int x, y;
    logic [15:0] acc16;
    longint acc;
    if (r.op == OP_WRITE) begin
      if (r.band < NBANDS) begin
        mb[r.band] = r.cb; ma1[r.band] = r.ca1; ma2[r.band] = r.ca2;
        if (r.on && !mon[r.band]) mcount++;
        if (!r.on && mon[r.band]) mcount--;
        mon[r.band] = r.on;
      end
      return;
    end
    x = r.smp;
    if (r.ps)
      for (int i = 0; i < 32; i++) begin
        hx1[i] = 0; hx2[i] = 0; hy1[i] = 0; hy2[i] = 0;
      end
    if (mcount == 0) begin
      exp_samples.push_back(r.smp);
      return;
    end
    acc16 = '0;
    for (int i = 0; i < NBANDS; i++) begin
      if (!mon[i]) continue;
      acc = longint'(mb[i]) * x - longint'(mb[i]) * hx2[i]
          - longint'(ma1[i]) * hy1[i] - longint'(ma2[i]) * hy2[i];
      y = trunc_sat16(acc);
      hx2[i] = hx1[i]; hx1[i] = x; hy2[i] = hy1[i]; hy1[i] = y;
      acc16 = acc16 + 16'(y / mcount);
    end
    exp_samples.push_back(acc16);
  endtask

  function automatic eq_req_t wr(int band, int cb, int ca1, int ca2, bit on, bit ps = 0);
    wr = '{OP_WRITE, 5'(band), 20'(cb), 20'(ca1), 20'(ca2), on, 16'(ps ? -1 : 0), ps, 1'b0};
  endfunction

  function automatic eq_req_t smp(int s, bit ps = 0);
    smp = '{OP_SAMPLE, 5'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
            1'($urandom), 16'(s), ps, 1'b0};
  endfunction

  function automatic eq_req_t rnd_write();
    eq_req_t r;
    r = wr($urandom_range(0, 31), 0, 0, 0, $urandom_range(0, 9) < 7, $urandom_range(0, 1));
    if ($urandom_range(0, 1)) begin
      r.cb = 20'($urandom); r.ca1 = 20'($urandom); r.ca2 = 20'($urandom);
    end else begin
      // modest coefficients keep the sections out of saturation
      r.cb  = 20'($signed($urandom_range(0, 8000)) - 4000);
      r.ca1 = 20'($signed($urandom_range(0, 200000)) - 100000);
      r.ca2 = 20'($signed($urandom_range(0, 100000)) - 50000);
    end
    return r;
  endfunction

  // Stimulus and end of run
  initial begin
    eq_req_t r;
    for (int i = 0; i < 32; i++) begin
      mb[i] = 0; ma1[i] = 0; ma2[i] = 0; mon[i] = 0;
      hx1[i] = 0; hx2[i] = 0; hy1[i] = 0; hy2[i] = 0;
    end
    mcount = 0;
    // directed: pass-through, extreme coefficients, ignored band, write-side period start
    pend.push_back(smp(32767));
    pend.push_back(smp(-32768));
    pend.push_back(wr(0, 524287, -524288, 524287, 1));
    pend.push_back(smp(32767));
    pend.push_back(smp(-32768));
    pend.push_back(smp(12345, 1));
    pend.push_back(wr(31, -524288, 524287, -524288, 1));
    pend.push_back(smp(-1));
    pend.push_back(wr(30, -524288, 0, 0, 1));
    pend.push_back(smp(-32768));
    pend.push_back(smp(32767));
    pend.push_back(wr(5, 3000, -90000, 40000, 1, 1));
    pend.push_back(smp(20000));
    pend.push_back(wr(0, 4000, 60000, -30000, 1));  // rewrite keeps history
    pend.push_back(smp(-20000));
    pend.push_back(wr(0, 0, 0, 0, 0));
    pend.push_back(smp(100));
    pend.push_back(wr(30, 0, 0, 0, 0));
    pend.push_back(wr(5, 0, 0, 0, 0));
    pend.push_back(smp(32767));
    pend.push_back(smp(0, 1));
    // random part, with a full bank phase and a drain-and-pause in the middle
    for (int k = 0; k < 300; k++) begin
      if (k == 150) begin
        for (int b = 0; b < 32; b++) pend.push_back(rnd_write());
        for (int b = 0; b < NBANDS; b++) begin
          r = rnd_write(); r.band = 5'(b); r.on = 1'b1; pend.push_back(r);
        end
        for (int j = 0; j < 8; j++) pend.push_back(smp($urandom_range(0, 65535)));
        for (int b = 0; b < NBANDS; b++) if (b % 3 != 0) pend.push_back(wr(b, 0, 0, 0, 0));
        r = smp($urandom_range(0, 65535)); r.sync = 1'b1; pend.push_back(r);
      end
      if ($urandom_range(0, 99) < 18) pend.push_back(rnd_write());
      else pend.push_back(smp($urandom_range(0, 65535), $urandom_range(0, 19) == 0));
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    while (pend.size() > 0 || s_valid || exp_samples.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Run covered %0d sample and %0d write requests, %0d outputs checked.",
             n_samples, n_writes, n_out);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Driver: bursts of requests with random gaps; hold while not taken
  int burst_left = 8, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && !(s_valid && !in_taken)) begin
      if (gap_left > 0) begin
        s_valid <= 1'b0;
        gap_left--;
      end else if (pend.size() > 0 && !(pend[0].sync && exp_samples.size() > 0)) begin
        cur <= pend.pop_front();
        s_valid <= 1'b1;
        if (--burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off
  int rx_mode = 0, rx_phase = 0, hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_out == 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (++rx_phase == 64) begin
        rx_phase = 0;
        rx_mode = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_ready <= 1'b1;
          1: m_ready <= $urandom_range(0, 1);
          2: m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= (rx_phase % 8) < 5;
        endcase
      end
    end
  end

  // Request side prediction and output checking at the rising edge
  always @(posedge clk_i) begin
    in_taken <= s_valid && s_axis_tready;
    if (rst_ni) begin
      if (s_valid && s_axis_tready) begin
        if (cur.op == OP_WRITE) n_writes++;
        else n_samples++;
        equalise(cur);
      end
      if (m_axis_tvalid && m_ready) begin
        n_out++;
        if (exp_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected output, expected none, actual %0d", $time,
                   $signed(m_axis_tdata));
        end else if (exp_samples[0] !== m_axis_tdata) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                   $signed(exp_samples[0]), $signed(m_axis_tdata));
          void'(exp_samples.pop_front());
        end else begin
          void'(exp_samples.pop_front());
        end
      end
    end
  end

  // Watchdog on stalled traffic
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) idle <= 0;
      else idle <= idle + 1;
      if (idle == IDLE_LIMIT) begin
        $display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
src/bbe_pkg.sv
src/bbe_datapath.sv
src/bbe_ctrl.sv
src/biquad_band_equalizer.sv
tb/sv/tb.sv
